// ----- rtl/het_pkg.sv -----
package het_pkg;

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 10;
  localparam int SIZE_RESET = 512;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_e;

  // Request operations
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_READ = 1'b1;

  // Label codes and edge output levels
  localparam logic [1:0] LBL_WEAK   = 2'd0;
  localparam logic [1:0] LBL_STRONG = 2'd2;
  localparam logic [7:0] EDGE_ON    = 8'd255;
  localparam logic [7:0] EDGE_OFF   = 8'd0;

  // 8-connected neighbor offsets, visited in this order
  localparam int NB_COUNT = 8;
  localparam int NB_KW    = 4;
  localparam logic signed [1:0] NB_DY [NB_COUNT] =
    '{-2'sd1, -2'sd1, -2'sd1, 2'sd0, 2'sd0, 2'sd1, 2'sd1, 2'sd1};
  localparam logic signed [1:0] NB_DX [NB_COUNT] =
    '{-2'sd1, 2'sd0, 2'sd1, -2'sd1, 2'sd1, -2'sd1, 2'sd0, 2'sd1};

  typedef struct packed {
    logic       op;
    logic [1:0] label_code;
    logic       final_load;
  } req_t;

  typedef struct packed {
    logic [7:0] edge_value;
    logic       final_read;
  } rsp_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_POP,
    ST_POP_WAIT,
    ST_BASE,
    ST_NB,
    ST_READ
  } state_e;

endpackage

// ----- rtl/het_stream_if.sv -----
interface het_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ----- rtl/het_ram.sv -----
module het_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/hysteresis_edge_tracking.sv -----
// Hysteresis edge tracking over one bordered label frame.
// Requests arrive on req_i. op=load writes the next label cell in raster order
// (0 weak, 2 strong, other suppressed); loads past width x height are dropped.
// A load with final_load set starts the fill; the block drops ready until the
// fill is done. op=read then returns the interior pixels in raster order on
// rsp_o, 255 for an edge and 0 otherwise, final_read set on the last one, after
// which the block is back to loading. A request of the wrong kind for the
// current phase is taken and dropped.
// Loads are accepted whenever the block is loading. A read's response passes
// through the label memory read register, then the output register; no read is
// taken while the last one's label read is pending. The fill reads and checks
// each interior pixel; a popped pixel costs a stack read, an address multiply,
// and up to eight shared label port reads pipelined against checks and writes.
// The response sits in an output register; a stalled receiver holds it and
// blocks further reads. A write on the cfg port restarts the frame.
// Reset returns to loading with an empty stack; there is no clearing pass,
// label memory holds whatever was last written.
module hysteresis_edge_tracking #(
  parameter int MAX_WIDTH   = 512,
  parameter int MAX_HEIGHT  = 512,
  parameter int STACK_DEPTH = 262144
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  het_stream_if.sink                      req_i,
  het_stream_if.source                    rsp_o,
  input  logic                            cfg_we_i,
  input  logic [het_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [het_pkg::CFG_DATA_W-1:0]  cfg_wdata_i
);

  localparam int XW    = $clog2(MAX_WIDTH);
  localparam int YW    = $clog2(MAX_HEIGHT);
  localparam int FWW   = $clog2(MAX_WIDTH + 1);
  localparam int FHW   = $clog2(MAX_HEIGHT + 1);
  localparam int CELLS = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(CELLS);
  localparam int SW    = $clog2(STACK_DEPTH);
  localparam int TW    = $clog2(STACK_DEPTH + 1);
  localparam int EW    = XW + YW;
  localparam int FW_RST = (het_pkg::SIZE_RESET > MAX_WIDTH) ? MAX_WIDTH : het_pkg::SIZE_RESET;
  localparam int FH_RST = (het_pkg::SIZE_RESET > MAX_HEIGHT) ? MAX_HEIGHT : het_pkg::SIZE_RESET;

  // Size clamps applied when a register is written
  function automatic logic [FWW-1:0] clamp_w(logic [het_pkg::CFG_DATA_W-1:0] raw);
    logic [FWW-1:0] res;
    if (raw < 3) res = FWW'(3);
    else if (int'(raw) > MAX_WIDTH) res = FWW'(MAX_WIDTH);
    else res = FWW'(raw);
    return res;
  endfunction

  function automatic logic [FHW-1:0] clamp_h(logic [het_pkg::CFG_DATA_W-1:0] raw);
    logic [FHW-1:0] res;
    if (raw < 3) res = FHW'(3);
    else if (int'(raw) > MAX_HEIGHT) res = FHW'(MAX_HEIGHT);
    else res = FHW'(raw);
    return res;
  endfunction

  het_pkg::state_e state_q, state_d;

  logic [FWW-1:0] fw_q;
  logic [FHW-1:0] fh_q;

  // Load counters
  logic [XW-1:0]  lx_q, lx_d;
  logic [FHW-1:0] ly_q, ly_d;
  logic [AW-1:0]  ld_addr_q, ld_addr_d;

  // Seed scan counters
  logic [XW-1:0]  sx_q, sx_d;
  logic [YW-1:0]  sy_q, sy_d;
  logic [AW-1:0]  scan_addr_q, scan_addr_d;

  // Readout counters
  logic [XW-1:0]  rx_q, rx_d;
  logic [YW-1:0]  ry_q, ry_d;
  logic [AW-1:0]  rd_addr_q, rd_addr_d;

  // Fill state
  logic [TW-1:0]  top_q, top_d;
  logic [XW-1:0]  cx_q, cx_d;
  logic [YW-1:0]  cy_q, cy_d;
  logic [AW-1:0]  base_q, base_d;
  logic [het_pkg::NB_KW-1:0] k_q, k_d;
  logic           pend_vld_q, pend_vld_d;
  logic [AW-1:0]  pend_addr_q, pend_addr_d;
  logic [XW-1:0]  pend_x_q, pend_x_d;
  logic [YW-1:0]  pend_y_q, pend_y_d;

  // Response path
  logic           rd_pend_q, rd_pend_d;
  logic           rd_last_q, rd_last_d;
  logic           out_vld_q, out_vld_d;
  het_pkg::rsp_t  out_q, out_d;

  // Memory ports
  logic           lbl_we, lbl_re;
  logic [AW-1:0]  lbl_waddr, lbl_raddr;
  logic [1:0]     lbl_wdata, lbl_rdata;
  logic           stk_we, stk_re;
  logic [SW-1:0]  stk_waddr, stk_raddr;
  logic [EW-1:0]  stk_wdata, stk_rdata;

  // Derived sizes
  logic [FWW-1:0] fw_m2, fw_m3;
  logic [FHW-1:0] fh_m2, fh_m3;
  logic [AW-1:0]  fw_a;
  logic [TW-1:0]  top_m1;

  assign fw_m2  = fw_q - FWW'(2);
  assign fw_m3  = fw_q - FWW'(3);
  assign fh_m2  = fh_q - FHW'(2);
  assign fh_m3  = fh_q - FHW'(3);
  assign fw_a   = AW'(fw_q);
  assign top_m1 = top_q - TW'(1);

  logic req_fire, ld_req, rd_req;
  assign req_fire = req_i.valid && req_i.ready;
  assign ld_req   = req_fire && (req_i.payload.op == het_pkg::OP_LOAD);
  assign rd_req   = req_fire && (req_i.payload.op == het_pkg::OP_READ);

  // Ready: always while loading, while reading only if the response path is free
  always_comb begin
    unique case (state_q)
      het_pkg::ST_LOAD: req_i.ready = 1'b1;
      het_pkg::ST_READ: req_i.ready = !rd_pend_q && (!out_vld_q || rsp_o.ready);
      default:          req_i.ready = 1'b0;
    endcase
  end

  assign rsp_o.valid   = out_vld_q;
  assign rsp_o.payload = out_q;

  // Scan and readout position tests
  logic scan_row_end, scan_end, rd_row_end, rd_last, stk_empty, stk_full;
  assign scan_row_end = FWW'(sx_q) == fw_m2;
  assign scan_end     = scan_row_end && (FHW'(sy_q) == fh_m2);
  assign rd_row_end   = FWW'(rx_q) == fw_m3;
  assign rd_last      = rd_row_end && (FHW'(ry_q) == fh_m3);
  assign stk_empty    = top_q == '0;
  assign stk_full     = top_q == TW'(STACK_DEPTH);

  // Neighbor k of the current center: bounds test and address
  logic signed [1:0] nb_dy, nb_dx;
  logic              nb_ok;
  logic [YW-1:0]     nb_y;
  logic [XW-1:0]     nb_x;
  logic [AW-1:0]     nb_row_off, nb_addr;

  always_comb begin
    nb_dy = het_pkg::NB_DY[k_q[2:0]];
    nb_dx = het_pkg::NB_DX[k_q[2:0]];
    nb_ok = !((nb_dy == -2'sd1) && (cy_q == YW'(1))) &&
            !((nb_dy ==  2'sd1) && (FHW'(cy_q) == fh_m2)) &&
            !((nb_dx == -2'sd1) && (cx_q == XW'(1))) &&
            !((nb_dx ==  2'sd1) && (FWW'(cx_q) == fw_m2));
    nb_y  = cy_q + {{(YW-2){nb_dy[1]}}, nb_dy};
    nb_x  = cx_q + {{(XW-2){nb_dx[1]}}, nb_dx};
    if (nb_dy == -2'sd1)     nb_row_off = -fw_a;
    else if (nb_dy == 2'sd1) nb_row_off = fw_a;
    else                     nb_row_off = '0;
    nb_addr = base_q + nb_row_off + {{(AW-2){nb_dx[1]}}, nb_dx};
  end

  // Sequencer next state
  always_comb begin
    state_d = state_q;
    if (cfg_we_i) begin
      state_d = het_pkg::ST_LOAD;
    end else begin
      unique case (state_q)
        het_pkg::ST_LOAD: begin
          if (ld_req && req_i.payload.final_load) state_d = het_pkg::ST_SCAN_RD;
        end
        het_pkg::ST_SCAN_RD:  state_d = het_pkg::ST_SCAN_CHK;
        het_pkg::ST_SCAN_CHK: begin
          if (lbl_rdata == het_pkg::LBL_STRONG) state_d = het_pkg::ST_POP;
          else if (scan_end)                    state_d = het_pkg::ST_READ;
          else                                  state_d = het_pkg::ST_SCAN_RD;
        end
        het_pkg::ST_POP: begin
          if (!stk_empty)    state_d = het_pkg::ST_POP_WAIT;
          else if (scan_end) state_d = het_pkg::ST_READ;
          else               state_d = het_pkg::ST_SCAN_RD;
        end
        het_pkg::ST_POP_WAIT: state_d = het_pkg::ST_BASE;
        het_pkg::ST_BASE:     state_d = het_pkg::ST_NB;
        het_pkg::ST_NB: begin
          if (k_q == het_pkg::NB_KW'(het_pkg::NB_COUNT)) state_d = het_pkg::ST_POP;
        end
        het_pkg::ST_READ: begin
          if (rd_req && rd_last) state_d = het_pkg::ST_LOAD;
        end
        default: state_d = het_pkg::ST_LOAD;
      endcase
    end
  end

  // Datapath, memory control and counters
  always_comb begin
    lx_d = lx_q; ly_d = ly_q; ld_addr_d = ld_addr_q;
    sx_d = sx_q; sy_d = sy_q; scan_addr_d = scan_addr_q;
    rx_d = rx_q; ry_d = ry_q; rd_addr_d = rd_addr_q;
    top_d = top_q; cx_d = cx_q; cy_d = cy_q; base_d = base_q; k_d = k_q;
    pend_vld_d = pend_vld_q; pend_addr_d = pend_addr_q;
    pend_x_d = pend_x_q; pend_y_d = pend_y_q;
    rd_pend_d = 1'b0;
    rd_last_d = rd_last_q;

    lbl_we    = 1'b0;
    lbl_waddr = ld_addr_q;
    lbl_wdata = req_i.payload.label_code;
    lbl_re    = 1'b0;
    lbl_raddr = scan_addr_q;
    stk_we    = 1'b0;
    stk_waddr = top_q[SW-1:0];
    stk_wdata = {sy_q, sx_q};
    stk_re    = 1'b0;
    stk_raddr = top_m1[SW-1:0];

    if (cfg_we_i) begin
      lx_d = '0; ly_d = '0; ld_addr_d = '0;
      top_d = '0;
      pend_vld_d = 1'b0;
    end else begin
      unique case (state_q)
        het_pkg::ST_LOAD: begin
          if (ld_req) begin
            if (ly_q != fh_q) begin
              lbl_we    = 1'b1;
              ld_addr_d = ld_addr_q + AW'(1);
              if (FWW'(lx_q) == fw_q - FWW'(1)) begin
                lx_d = '0;
                ly_d = ly_q + FHW'(1);
              end else begin
                lx_d = lx_q + XW'(1);
              end
            end
            if (req_i.payload.final_load) begin
              lx_d = '0; ly_d = '0; ld_addr_d = '0;
              sx_d = XW'(1); sy_d = YW'(1); scan_addr_d = fw_a + AW'(1);
              rx_d = '0; ry_d = '0; rd_addr_d = fw_a + AW'(1);
            end
          end
        end
        het_pkg::ST_SCAN_RD: begin
          lbl_re = 1'b1;
        end
        het_pkg::ST_SCAN_CHK, het_pkg::ST_POP: begin
          if (state_q == het_pkg::ST_SCAN_CHK && lbl_rdata == het_pkg::LBL_STRONG) begin
            // New seed: restart the stack with it
            stk_we    = 1'b1;
            stk_waddr = '0;
            top_d     = TW'(1);
          end else if (state_q == het_pkg::ST_POP && !stk_empty) begin
            stk_re = 1'b1;
            top_d  = top_m1;
          end else if (!scan_end) begin
            if (scan_row_end) begin
              sx_d = XW'(1);
              sy_d = sy_q + YW'(1);
              scan_addr_d = scan_addr_q + AW'(3);
            end else begin
              sx_d = sx_q + XW'(1);
              scan_addr_d = scan_addr_q + AW'(1);
            end
          end
        end
        het_pkg::ST_POP_WAIT: begin
          cy_d = stk_rdata[EW-1:XW];
          cx_d = stk_rdata[XW-1:0];
        end
        het_pkg::ST_BASE: begin
          base_d     = AW'(cy_q) * fw_a + AW'(cx_q);
          k_d        = '0;
          pend_vld_d = 1'b0;
        end
        het_pkg::ST_NB: begin
          // Check the neighbor read last cycle: promote it, and push it if the stack has room
          if (pend_vld_q && lbl_rdata == het_pkg::LBL_WEAK) begin
            lbl_we    = 1'b1;
            lbl_waddr = pend_addr_q;
            lbl_wdata = het_pkg::LBL_STRONG;
            if (!stk_full) begin
              stk_we    = 1'b1;
              stk_wdata = {pend_y_q, pend_x_q};
              top_d     = top_q + TW'(1);
            end
          end
          // Issue the read of neighbor k
          if (k_q == het_pkg::NB_KW'(het_pkg::NB_COUNT)) begin
            pend_vld_d = 1'b0;
          end else begin
            lbl_re      = nb_ok;
            lbl_raddr   = nb_addr;
            pend_vld_d  = nb_ok;
            pend_addr_d = nb_addr;
            pend_x_d    = nb_x;
            pend_y_d    = nb_y;
            k_d         = k_q + het_pkg::NB_KW'(1);
          end
        end
        het_pkg::ST_READ: begin
          if (rd_req) begin
            lbl_re    = 1'b1;
            lbl_raddr = rd_addr_q;
            rd_pend_d = 1'b1;
            rd_last_d = rd_last;
            if (rd_last) begin
              lx_d = '0; ly_d = '0; ld_addr_d = '0;
            end else if (rd_row_end) begin
              rx_d = '0;
              ry_d = ry_q + YW'(1);
              rd_addr_d = rd_addr_q + AW'(3);
            end else begin
              rx_d = rx_q + XW'(1);
              rd_addr_d = rd_addr_q + AW'(1);
            end
          end
        end
        default: begin
          top_d = '0;
        end
      endcase
    end
  end

  // Output register
  always_comb begin
    out_vld_d = out_vld_q;
    out_d     = out_q;
    if (rd_pend_q) begin
      out_vld_d        = 1'b1;
      out_d.edge_value = (lbl_rdata == het_pkg::LBL_STRONG) ? het_pkg::EDGE_ON
                                                            : het_pkg::EDGE_OFF;
      out_d.final_read = rd_last_q;
    end else if (rsp_o.ready) begin
      out_vld_d = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= het_pkg::ST_LOAD;
      fw_q       <= FWW'(FW_RST);
      fh_q       <= FHW'(FH_RST);
      lx_q       <= '0;
      ly_q       <= '0;
      ld_addr_q  <= '0;
      top_q      <= '0;
      pend_vld_q <= 1'b0;
      rd_pend_q  <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      lx_q       <= lx_d;
      ly_q       <= ly_d;
      ld_addr_q  <= ld_addr_d;
      top_q      <= top_d;
      pend_vld_q <= pend_vld_d;
      rd_pend_q  <= rd_pend_d;
      out_vld_q  <= out_vld_d;
      if (cfg_we_i) begin
        if (cfg_idx_i == het_pkg::REG_FRAME_WIDTH) fw_q <= clamp_w(cfg_wdata_i);
        else                                       fh_q <= clamp_h(cfg_wdata_i);
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    sx_q        <= sx_d;
    sy_q        <= sy_d;
    scan_addr_q <= scan_addr_d;
    rx_q        <= rx_d;
    ry_q        <= ry_d;
    rd_addr_q   <= rd_addr_d;
    cx_q        <= cx_d;
    cy_q        <= cy_d;
    base_q      <= base_d;
    k_q         <= k_d;
    pend_addr_q <= pend_addr_d;
    pend_x_q    <= pend_x_d;
    pend_y_q    <= pend_y_d;
    rd_last_q   <= rd_last_d;
    out_q       <= out_d;
  end

  // Label frame
  het_ram #(
    .WIDTH (2),
    .DEPTH (CELLS)
  ) u_label_ram (
    .clk_i   (clk_i),
    .we_i    (lbl_we),
    .waddr_i (lbl_waddr),
    .wdata_i (lbl_wdata),
    .re_i    (lbl_re),
    .raddr_i (lbl_raddr),
    .rdata_o (lbl_rdata)
  );

  // Pending pixel stack, entries hold {y, x}
  het_ram #(
    .WIDTH (EW),
    .DEPTH (STACK_DEPTH)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (stk_waddr),
    .wdata_i (stk_wdata),
    .re_i    (stk_re),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rdata)
  );

  // The stack is drained before loading or reading resumes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == het_pkg::ST_LOAD || state_q == het_pkg::ST_READ) |-> top_q == '0)
    else $error("stack not empty outside fill");

  // A read response never lands on an unconsumed one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_pend_q |-> !out_vld_q)
    else $error("response register overrun");

  // Neighbor checks only run inside the neighbor sweep
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_vld_q |-> state_q == het_pkg::ST_NB)
    else $error("stray neighbor check");

  // No request is taken during the fill
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_fire |-> (state_q == het_pkg::ST_LOAD || state_q == het_pkg::ST_READ))
    else $error("request taken during fill");

  // Stack depth stays bounded
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    stk_we && state_q == het_pkg::ST_NB |-> !stk_full)
    else $error("push on full stack");

endmodule
